### design/bblur_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
// No dependencies; compiled before every other file of the block.

package bblur_pkg;

    // Channel and pixel widths.
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;

    // Widths of the frame size registers and of the row counter.
    localparam int FRAME_W_BITS = 11;
    localparam int FRAME_H_BITS = 12;
    localparam int ROW_W        = FRAME_H_BITS + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Reset values of the frame size registers.
    localparam logic [FRAME_W_BITS-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [FRAME_H_BITS-1:0] RESET_HEIGHT = 12'd480;

    // Sum of nine channel values and the reciprocal used to divide it by nine.
    localparam int SUM_W       = CHAN_W + 4;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    // Result queue.
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_PTR_W = 3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } result_t;

endpackage

### design/bblur_cfg_if.sv
// Configuration write channel of the box blur.
// Depends on bblur_pkg.

interface bblur_cfg_if;
    import bblur_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/bblur_pixel_if.sv
// Input pixel channel of the box blur: pixel beats and flush ticks.
// Depends on bblur_pkg.

interface bblur_pixel_if;
    import bblur_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, output kind, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink   (input valid, input kind, input red_in, input green_in,
                    input blue_in, output ready);
endinterface

### design/bblur_result_if.sv
// Output pixel channel of the box blur.
// Depends on bblur_pkg.

interface bblur_result_if;
    import bblur_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;

    modport source (output valid, output red_out, output green_out,
                    output blue_out, output frame_end, input ready);
    modport sink   (input valid, input red_out, input green_out,
                    input blue_out, input frame_end, output ready);
endinterface

### design/bblur_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; read during write of the same address returns the old data.

module bblur_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/box_blur_3x3_rgb_unit.sv
// Top level of the streaming 3x3 RGB box blur with its two-line store.
// Depends on bblur_pkg, the three channel interfaces and bblur_ram.
//
//   channel  interface        role    payload
//   cfg      bblur_cfg_if     sink    index, data (frame_width, frame_height)
//   pixel    bblur_pixel_if   sink    kind, red_in, green_in, blue_in
//   result   bblur_result_if  source  red_out, green_out, blue_out, frame_end
//
// One beat is accepted per clock while pixel is not stalled. A result is offered
// once the beat releasing it has passed the line store read, window update, adder
// tree, then the multiply that writes the result queue.
// The line store needs no clearing pass after reset; cfg is always ready.
// pixel stalls only when the eight-entry result queue plus the results still
// in the pipeline would overflow, i.e. when result is held back.

module box_blur_3x3_rgb_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    bblur_cfg_if.sink      cfg,
    bblur_pixel_if.sink    pixel,
    bblur_result_if.source result
);
    import bblur_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ACT_W = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = OFIFO_PTR_W + 1;

    // Configuration registers and the frame size latched at frame start.
    logic [FRAME_W_BITS-1:0] cfg_width_reg;
    logic [FRAME_H_BITS-1:0] cfg_height_reg;
    logic [ACT_W-1:0]        act_w_reg, act_w_next;
    logic [FRAME_H_BITS-1:0] act_h_reg, act_h_next;

    // Raster position counters.
    logic [COL_W-1:0]        in_col_reg, in_col_next;
    logic [ROW_W-1:0]        in_row_reg, in_row_next;
    logic [COL_W-1:0]        out_col_reg, out_col_next;
    logic [FRAME_H_BITS-1:0] out_row_reg, out_row_next;

    // Decode of the beat at the input.
    logic                    in_fire;
    logic                    frame_start;
    logic                    drop;
    logic [ACT_W-1:0]        sat_w;
    logic [FRAME_H_BITS-1:0] sat_h;
    logic [ACT_W-1:0]        eff_w;
    logic [FRAME_H_BITS-1:0] eff_h;
    logic                    pix_blank;
    logic [PIX_W-1:0]        pix_val;
    logic                    emit;
    logic [ACT_W-1:0]        col_inc;
    logic [ACT_W-1:0]        out_col_inc;
    logic                    last_out;
    logic                    frame_done;
    logic                    interior;
    logic                    hazard;

    // Stage 1: line store read data arrives, write back, window shift.
    logic                    s1_valid_reg;
    logic                    s1_emit_reg;
    logic                    s1_fwd_reg;
    logic                    s1_interior_reg;
    logic                    s1_fe_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic [PIX_W-1:0]        s1_pix_reg;
    logic [2*PIX_W-1:0]      ram_rdata;
    logic [2*PIX_W-1:0]      fwd_data_reg;
    logic [2*PIX_W-1:0]      line_data;
    logic [PIX_W-1:0]        line_top;
    logic [PIX_W-1:0]        line_mid;
    logic [2*PIX_W-1:0]      ram_wdata;
    logic [PIX_W-1:0]        win_reg  [3][3];
    logic [PIX_W-1:0]        win_next [3][3];

    // Stage 2: adder tree over the window.
    logic                    s2_valid_reg;
    logic                    s2_interior_reg;
    logic                    s2_fe_reg;
    logic [SUM_W-1:0]        win_sum [3];

    // Stage 3: divide by nine and select the result.
    logic                    s3_valid_reg;
    logic                    s3_interior_reg;
    logic                    s3_fe_reg;
    logic [SUM_W-1:0]        s3_sum_reg [3];
    logic [PIX_W-1:0]        s3_center_reg;
    logic [SUM_W+RECIP_W-1:0] prod [3];
    result_t                 s3_result;

    // Result queue.
    result_t                 ofifo_mem [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [OFIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        credit;
    logic                    pop;
    result_t                 head;

    // Configuration writes; the port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= RESET_WIDTH;
            cfg_height_reg <= RESET_HEIGHT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_FRAME_WIDTH:  cfg_width_reg  <= cfg.data[FRAME_W_BITS-1:0];
                REG_FRAME_HEIGHT: cfg_height_reg <= cfg.data[FRAME_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Frame size as taken at the first beat of a frame.
    always_comb
    begin
        if (cfg_width_reg == '0)
        begin
            sat_w = ACT_W'(1);
        end
        else if (32'(cfg_width_reg) > 32'(MAX_WIDTH))
        begin
            sat_w = ACT_W'(MAX_WIDTH);
        end
        else
        begin
            sat_w = ACT_W'(cfg_width_reg);
        end
        sat_h = (cfg_height_reg == '0) ? FRAME_H_BITS'(1) : cfg_height_reg;
    end

    // Input flow control: room for every result already in flight.
    assign credit = count_reg + CNT_W'(s1_valid_reg & s1_emit_reg)
                  + CNT_W'(s2_valid_reg) + CNT_W'(s3_valid_reg);
    assign pixel.ready = (credit < CNT_W'(OFIFO_DEPTH));
    assign in_fire     = pixel.valid && pixel.ready;

    // Decode of the incoming beat against the raster counters.
    always_comb
    begin
        frame_start = (in_row_reg == '0) && (in_col_reg == '0);
        eff_w       = frame_start ? sat_w : act_w_reg;
        eff_h       = frame_start ? sat_h : act_h_reg;
        drop        = frame_start && pixel.kind;
        pix_blank   = pixel.kind || (in_row_reg >= {1'b0, eff_h});
        pix_val     = pix_blank ? '0 : {pixel.red_in, pixel.green_in, pixel.blue_in};
        emit        = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        col_inc     = ACT_W'(in_col_reg) + ACT_W'(1);
        out_col_inc = ACT_W'(out_col_reg) + ACT_W'(1);
        last_out    = (out_row_reg == eff_h - FRAME_H_BITS'(1))
                   && (out_col_inc == eff_w);
        frame_done  = emit && last_out;
        interior    = (out_row_reg != '0)
                   && (({1'b0, out_row_reg} + ROW_W'(1)) < {1'b0, eff_h})
                   && (out_col_reg != '0)
                   && (out_col_inc < eff_w);
        hazard      = s1_valid_reg && (s1_col_reg == in_col_reg);
    end

    // Next values of the raster counters and the latched frame size.
    always_comb
    begin
        act_w_next   = act_w_reg;
        act_h_next   = act_h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (in_fire && !drop)
        begin
            if (frame_start)
            begin
                act_w_next = sat_w;
                act_h_next = sat_h;
            end
            if (frame_done)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (col_inc >= eff_w)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = COL_W'(col_inc);
                end
                if (emit)
                begin
                    if (out_col_inc >= eff_w)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + FRAME_H_BITS'(1);
                    end
                    else
                    begin
                        out_col_next = COL_W'(out_col_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_w_reg   <= ACT_W'(RESET_WIDTH);
            act_h_reg   <= RESET_HEIGHT;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            act_w_reg   <= act_w_next;
            act_h_reg   <= act_h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Stage 1 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire && !drop;
        end
    end

    // Stage 1 payload, captured with the line store read.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_emit_reg     <= emit;
            s1_fwd_reg      <= hazard;
            s1_interior_reg <= interior;
            s1_fe_reg       <= frame_done;
            s1_col_reg      <= in_col_reg;
            s1_pix_reg      <= pix_val;
        end
    end

    // Line store: each entry holds the two rows above the current column.
    bblur_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // Forward the previous write when it hit the entry being read.
    assign line_data = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    assign line_top  = line_data[2*PIX_W-1:PIX_W];
    assign line_mid  = line_data[PIX_W-1:0];
    assign ram_wdata = {line_mid, s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            fwd_data_reg <= ram_wdata;
        end
    end

    // Window shift: the new column enters on the right.
    always_comb
    begin
        win_next = win_reg;
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = line_top;
            win_next[1][2] = line_mid;
            win_next[2][2] = s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // Stage 2 control: only beats that release a result go on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_interior_reg <= s1_interior_reg;
        s2_fe_reg       <= s1_fe_reg;
    end

    // Per-channel sum of the nine window pixels.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_sum[k] = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_sum[k] = win_sum[k]
                               + SUM_W'(win_reg[r][c][PIX_W-1-CHAN_W*k -: CHAN_W]);
                end
            end
        end
    end

    // Stage 3 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_interior_reg <= s2_interior_reg;
        s3_fe_reg       <= s2_fe_reg;
        s3_sum_reg      <= win_sum;
        s3_center_reg   <= win_reg[1][1];
    end

    // Divide by nine with a reciprocal multiply; borders pass the center.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = (SUM_W+RECIP_W)'(s3_sum_reg[k]) * (SUM_W+RECIP_W)'(RECIP_NINE);
        end
        if (s3_interior_reg)
        begin
            s3_result.red   = prod[0][RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
            s3_result.green = prod[1][RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
            s3_result.blue  = prod[2][RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
        end
        else
        begin
            s3_result.red   = s3_center_reg[PIX_W-1:2*CHAN_W];
            s3_result.green = s3_center_reg[2*CHAN_W-1:CHAN_W];
            s3_result.blue  = s3_center_reg[CHAN_W-1:0];
        end
        s3_result.frame_end = s3_fe_reg;
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            ofifo_mem[wr_ptr_reg] <= s3_result;
        end
    end

    // Result queue pointers and fill count.
    assign pop = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (s3_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + OFIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OFIFO_PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(s3_valid_reg) - CNT_W'(pop);
        end
    end

    // Output beat from the head of the queue.
    assign head             = ofifo_mem[rd_ptr_reg];
    assign result.valid     = (count_reg != '0);
    assign result.red_out   = head.red;
    assign result.green_out = head.green;
    assign result.blue_out  = head.blue;
    assign result.frame_end = head.frame_end;

endmodule

### design/bblur_chk.sv
// Port-level checker for the box blur and the bind that attaches it.
// Depends on bblur_pkg and box_blur_3x3_rgb_unit.

module bblur_chk (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [bblur_pkg::CHAN_W-1:0] out_red,
    input logic [bblur_pkg::CHAN_W-1:0] out_green,
    input logic [bblur_pkg::CHAN_W-1:0] out_blue,
    input logic                   out_frame_end
);
    import bblur_pkg::*;

    logic in_accept;

    assign in_accept = in_valid && in_ready;

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
                                    && $stable(out_blue) && $stable(out_frame_end))
        else $error("result payload changed while stalled");

    // Nothing is offered right after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !out_valid)
        else $error("result offered straight out of reset");

    // A result that appears on an empty output comes from an earlier accepted input beat.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_accept, 4))
        else $error("result appeared without a matching input beat");

endmodule

bind box_blur_3x3_rgb_unit bblur_chk u_bblur_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixel.valid),
    .in_ready      (pixel.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_red       (result.red_out),
    .out_green     (result.green_out),
    .out_blue      (result.blue_out),
    .out_frame_end (result.frame_end)
);

### dv/tb_box_blur_3x3_rgb_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_blur_3x3_rgb_unit: directed and random frames,
// checked beat by beat against a line-store model of the 3x3 box blur.
// Depends on bblur_pkg, the three bblur channel interfaces and the block's RTL.

module tb_box_blur_3x3_rgb_unit;
    import bblur_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int BLUR_TAPS     = 9;
    localparam int RANDOM_BEATS  = 1100;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic {
        BEAT_PIXEL = 1'b0,
        BEAT_FLUSH = 1'b1
    } beat_kind_t;

    typedef struct packed {
        beat_kind_t        kind;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bblur_cfg_if    cfg_bus ();
    bblur_pixel_if  pixel_bus ();
    bblur_result_if result_bus ();

    box_blur_3x3_rgb_unit #(
        .MAX_WIDTH(LINE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus.sink),
        .pixel (pixel_bus.sink),
        .result(result_bus.source)
    );

    // Beats waiting for the driver and blurred pixels waiting for the block.
    pixel_beat_t pending_beats [$];
    result_t     expected_pixels [$];
    pixel_beat_t next_beat;

    int beats_queued    = 0;
    int beats_taken     = 0;
    int results_checked = 0;
    int frames_seen     = 0;
    int settings_used   = 0;
    int error_count     = 0;

    // Model of the block: two line stores, the 3x3 window and the raster counters.
    logic [PIX_W-1:0]        upper_row  [LINE_DEPTH];
    logic [PIX_W-1:0]        middle_row [LINE_DEPTH];
    logic [PIX_W-1:0]        win [3][3];
    int unsigned             in_col;
    int unsigned             in_row;
    int unsigned             out_pos;
    int unsigned             eff_w;
    int unsigned             eff_h;
    logic [FRAME_W_BITS-1:0] cfg_width;
    logic [FRAME_H_BITS-1:0] cfg_height;

    // Idle state of both sides.
    int src_gap   = 0;
    int src_calm  = 0;
    int snk_stall = 0;
    int snk_calm  = 0;
    int stall_draw;

    // Mean of one channel over the whole window, truncated.
    function automatic logic [CHAN_W-1:0] window_mean(input int shift);
        int unsigned sum;
        sum = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                sum += (win[r][c] >> shift) & 24'hFF;
        window_mean = CHAN_W'(sum / BLUR_TAPS);
    endfunction

    // Wait before the next beat: drawn at random, with occasional stretches of none.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            draw_gap = 0;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            calm_left = $urandom_range(16, 48);
            draw_gap  = 0;
        end
        else
            draw_gap = $urandom_range(0, 9);
    endfunction

    // Channel value with the extremes drawn more often than chance.
    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(0, 9))
            0:       pick_chan = 8'h00;
            1:       pick_chan = 8'hFF;
            default: pick_chan = CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the model by one accepted input beat and queue the pixel it releases.
    task automatic predict_blur(input logic kind, input logic [CHAN_W-1:0] r, g, b);
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        int unsigned      total;
        int unsigned      p;
        int unsigned      qr;
        int unsigned      qc;
        result_t          res;

        // The first beat of a frame latches the size; a flush there is ignored.
        if (in_row == 0 && in_col == 0)
        begin
            if (kind)
                return;
            eff_w = (cfg_width == 0) ? 1 : cfg_width;
            if (eff_w > LINE_DEPTH)
                eff_w = LINE_DEPTH;
            eff_h = (cfg_height == 0) ? 1 : cfg_height;
        end

        // Flush ticks and surplus pixels enter the window as black.
        total = eff_w * eff_h;
        p     = in_row * eff_w + in_col;
        px    = (kind || p >= total) ? '0 : {r, g, b};

        top                = upper_row[in_col];
        mid                = middle_row[in_col];
        upper_row[in_col]  = mid;
        middle_row[in_col] = px;

        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;

        in_col++;
        if (in_col >= eff_w)
        begin
            in_col = 0;
            in_row++;
        end

        // Nothing comes out until the window centre holds the first pixel.
        if (p < eff_w + 1)
            return;

        qr = out_pos / eff_w;
        qc = out_pos % eff_w;
        if (qr >= 1 && qr + 1 < eff_h && qc >= 1 && qc + 1 < eff_w)
        begin
            res.red   = window_mean(16);
            res.green = window_mean(8);
            res.blue  = window_mean(0);
        end
        else
        begin
            res.red   = win[1][1][23:16];
            res.green = win[1][1][15:8];
            res.blue  = win[1][1][7:0];
        end

        // The last pixel of the frame returns every counter to the start.
        if (out_pos + 1 >= total)
        begin
            res.frame_end = 1'b1;
            in_col        = 0;
            in_row        = 0;
            out_pos       = 0;
        end
        else
        begin
            res.frame_end = 1'b0;
            out_pos       = out_pos + 1;
        end
        expected_pixels = {expected_pixels, res};
    endtask

    // Pixel driver: presents queued beats, each followed by a drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bus.valid    <= 1'b0;
            pixel_bus.kind     <= 1'b0;
            pixel_bus.red_in   <= '0;
            pixel_bus.green_in <= '0;
            pixel_bus.blue_in  <= '0;
            src_gap            <= 0;
        end
        else if (!pixel_bus.valid || pixel_bus.ready)
        begin
            if (src_gap > 0)
            begin
                src_gap         <= src_gap - 1;
                pixel_bus.valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                next_beat          = pending_beats.pop_front();
                pixel_bus.valid    <= 1'b1;
                pixel_bus.kind     <= next_beat.kind;
                pixel_bus.red_in   <= next_beat.red;
                pixel_bus.green_in <= next_beat.green;
                pixel_bus.blue_in  <= next_beat.blue;
                src_gap            <= draw_gap(src_calm);
            end
            else
                pixel_bus.valid <= 1'b0;
        end
    end

    // Result sink: after each accepted beat, holds ready low for a drawn stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            snk_stall        <= 0;
        end
        else if (result_bus.valid && result_bus.ready)
        begin
            stall_draw = draw_gap(snk_calm);
            snk_stall        <= stall_draw;
            result_bus.ready <= (stall_draw == 0);
        end
        else if (snk_stall > 0)
        begin
            snk_stall        <= snk_stall - 1;
            result_bus.ready <= (snk_stall == 1);
        end
        else
            result_bus.ready <= 1'b1;
    end

    // Monitor: tracks register writes, predicts from input beats, checks result beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            in_col     = 0;
            in_row     = 0;
            out_pos    = 0;
            cfg_width  = RESET_WIDTH;
            cfg_height = RESET_HEIGHT;
            eff_w      = RESET_WIDTH;
            eff_h      = RESET_HEIGHT;
        end
        else
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                if (cfg_bus.index == REG_FRAME_WIDTH)
                    cfg_width = cfg_bus.data[FRAME_W_BITS-1:0];
                else
                    cfg_height = cfg_bus.data[FRAME_H_BITS-1:0];
            end

            if (pixel_bus.valid && pixel_bus.ready)
            begin
                beats_taken++;
                predict_blur(pixel_bus.kind, pixel_bus.red_in, pixel_bus.green_in,
                             pixel_bus.blue_in);
            end

            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result beat with no pixel expected");
                    error_count++;
                end
                else
                begin
                    automatic result_t want = expected_pixels.pop_front();
                    results_checked++;
                    if (want.frame_end)
                        frames_seen++;
                    if (result_bus.red_out !== want.red)
                    begin
                        $error("red_out: expected %0d, actual %0d", want.red,
                               result_bus.red_out);
                        error_count++;
                    end
                    if (result_bus.green_out !== want.green)
                    begin
                        $error("green_out: expected %0d, actual %0d", want.green,
                               result_bus.green_out);
                        error_count++;
                    end
                    if (result_bus.blue_out !== want.blue)
                    begin
                        $error("blue_out: expected %0d, actual %0d", want.blue,
                               result_bus.blue_out);
                        error_count++;
                    end
                    if (result_bus.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0d, actual %0d", want.frame_end,
                               result_bus.frame_end);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic push_beat(input beat_kind_t beat_kind, input logic [CHAN_W-1:0] r, g, b);
        pixel_beat_t beat;
        beat.kind       = beat_kind;
        beat.red        = r;
        beat.green      = g;
        beat.blue       = b;
        pending_beats   = {pending_beats, beat};
        beats_queued++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits until every beat is taken and every expected pixel has come back.
    task automatic wait_drained(input int settle);
        while (beats_taken != beats_queued || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // One complete frame: its pixels, then width+1 trailing beats that flush it.
    // Noisy frames swap some pixels for early flushes and some flushes for
    // surplus pixels; some frames pause at a random beat until the block has drained.
    // The first beat always stays a pixel so that the frame starts where queued.
    task automatic queue_frame(input int w, input int h, output int items);
        int pixels;
        int noise_pct;
        int split_at;
        bit noisy;

        pixels    = w * h;
        items     = pixels + w + 1;
        noise_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : 0;
        split_at  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, items - 1) : -1;

        // Flush ticks between frames are ignored by the block.
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                push_beat(BEAT_FLUSH, pick_chan(), pick_chan(), pick_chan());

        for (int k = 0; k < items; k++)
        begin
            if (k == split_at)
                wait_drained(0);
            noisy = (k != 0) && ($urandom_range(0, 99) < noise_pct);
            if ((k < pixels) != noisy)
                push_beat(BEAT_PIXEL, pick_chan(), pick_chan(), pick_chan());
            else
                push_beat(BEAT_FLUSH, pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    // Writes both size registers while the block is idle, then queues frames.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] w_data, h_data,
                             input int frames, output int items);
        int w;
        int h;
        int frame_items;

        wait_drained(SETTLE_CYCLES);
        write_reg(REG_FRAME_WIDTH, w_data);
        write_reg(REG_FRAME_HEIGHT, h_data);
        settings_used++;

        w = int'(w_data[FRAME_W_BITS-1:0]);
        if (w == 0)
            w = 1;
        else if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        h = int'(h_data);
        if (h == 0)
            h = 1;

        items = 0;
        repeat (frames)
        begin
            queue_frame(w, h, frame_items);
            items += frame_items;
        end
    endtask

    // Stimulus.
    initial
    begin
        int random_items;
        int items;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;

        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_FRAME_WIDTH;
        cfg_bus.data        = '0;
        pixel_bus.valid     = 1'b0;
        pixel_bus.kind      = 1'b0;
        pixel_bus.red_in    = '0;
        pixel_bus.green_in  = '0;
        pixel_bus.blue_in   = '0;
        result_bus.ready    = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x3 frame: an idle flush first, an early flush as the last pixel,
        // and a surplus pixel among the trailing flushes.
        write_reg(REG_FRAME_WIDTH, 12'd3);
        write_reg(REG_FRAME_HEIGHT, 12'd3);
        settings_used++;
        push_beat(BEAT_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 8; i++)
            push_beat(BEAT_PIXEL, (i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF,
                      (i < 4) ? 8'h80 : 8'h7F);
        push_beat(BEAT_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        push_beat(BEAT_FLUSH, 8'h00, 8'h00, 8'h00);
        push_beat(BEAT_FLUSH, 8'hFF, 8'h00, 8'hFF);
        push_beat(BEAT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        push_beat(BEAT_FLUSH, 8'h00, 8'hFF, 8'h00);

        // Zero width and zero height are both taken as one.
        wait_drained(SETTLE_CYCLES);
        write_reg(REG_FRAME_WIDTH, 12'd0);
        write_reg(REG_FRAME_HEIGHT, 12'd0);
        settings_used++;
        push_beat(BEAT_PIXEL, 8'hA5, 8'h5A, 8'hFF);
        push_beat(BEAT_PIXEL, 8'h01, 8'h80, 8'hFE);
        push_beat(BEAT_FLUSH, 8'h00, 8'h00, 8'h00);

        // Random sizes, mostly small frames.
        random_items = 0;
        while (random_items < RANDOM_BEATS)
        begin
            case ($urandom_range(0, 9))
                0:       w_data = 12'd0;
                1, 2:    w_data = CFG_DATA_W'($urandom_range(11, 40));
                default: w_data = CFG_DATA_W'($urandom_range(1, 10));
            endcase
            h_data = (w_data > 10) ? CFG_DATA_W'($urandom_range(0, 5))
                                   : CFG_DATA_W'($urandom_range(0, 12));
            run_phase(w_data, h_data, $urandom_range(1, 3), items);
            random_items += items;
        end

        // A width with its top data bit set keeps only the register's low bits.
        run_phase(12'h802, 12'd4, 1, items);

        wait_drained(16);
        $display("Checked %0d blurred pixels over %0d frames from %0d input beats,",
                 results_checked, frames_seen, beats_taken);
        $display("using %0d frame size settings with random gaps and stalls.",
                 settings_used);
        if (error_count == 0)
            $display("tb_box_blur_3x3_rgb_unit passed");
        else
            $display("tb_box_blur_3x3_rgb_unit failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("tb_box_blur_3x3_rgb_unit failed");
        $finish;
    end

endmodule
